/* src/assert_macros.svh */
// Assertion macros shared by the Modbus RTU receiver modules.
// Expects clk_i and rst_ni in the scope of every use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define MB_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define MB_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);
`else
`define MB_ASSERT(lbl, prop, msg)
`define MB_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

/* src/mbrtu_pkg.sv */
// Types, constants and helper functions for the Modbus RTU frame receiver.
// No dependencies; used by every module of the block.
package mbrtu_pkg;

  // Frame size limit and derived widths
  localparam int unsigned MAX_FRAME_BYTES = 256;
  localparam int unsigned LEN_W           = 11;  // holds count + data + crc sums
  localparam int unsigned QUEUE_DEPTH     = 2;
  localparam int unsigned QPTR_W          = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W          = $clog2(QUEUE_DEPTH + 1);

  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hA001;

  // Configuration register indexes
  localparam logic CFG_OWN_ADDRESS  = 1'b0;
  localparam logic CFG_MESSAGE_KIND = 1'b1;

  // Input item kinds
  localparam logic FUNC_BYTE    = 1'b0;
  localparam logic FUNC_TIMEOUT = 1'b1;

  typedef enum logic [2:0] {
    ST_RECEIVING   = 3'd0,
    ST_FRAME_OK    = 3'd1,
    ST_OTHER_SLAVE = 3'd2,
    ST_CRC_ERROR   = 3'd3,
    ST_TOO_LONG    = 3'd4,
    ST_TIMEOUT     = 3'd5
  } status_e;

  typedef enum logic [1:0] {
    PH_HEAD = 2'd0,
    PH_META = 2'd1,
    PH_DATA = 2'd2
  } phase_e;

  typedef struct packed {
    logic       func;
    logic [7:0] rx_byte;
  } in_item_t;

  typedef struct packed {
    logic [2:0] status;
    logic [7:0] byte_index;
    logic [7:0] data_byte;
    logic [7:0] function_code;
    logic [8:0] frame_length;
  } out_item_t;

  // Classified entry in the front-to-back queue
  typedef struct packed {
    logic       is_timeout;
    logic [7:0] data;
  } q_item_t;

  // Queue head as seen by the back end
  typedef struct packed {
    logic    valid;
    q_item_t item;
  } q_head_t;

  // One byte of CRC-16/Modbus, reflected polynomial
  function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) c = (c >> 1) ^ CRC_POLY;
      else      c = c >> 1;
    end
    return c;
  endfunction

  // Meta part length after address and function
  function automatic logic [3:0] meta_length(input logic [7:0] fc, input logic kind);
    logic [3:0] m;
    m = 4'd0;
    if (kind == 1'b0) begin
      case (fc) inside
        [8'd0:8'd6]:  m = 4'd4;
        8'd15, 8'd16: m = 4'd5;
        8'd22:        m = 4'd6;
        8'd23:        m = 4'd9;
        default:      m = 4'd0;
      endcase
    end else begin
      case (fc) inside
        8'd5, 8'd6, 8'd15, 8'd16: m = 4'd4;
        8'd22:                    m = 4'd6;
        default:                  m = 4'd1;
      endcase
    end
    return m;
  endfunction

  // Last meta byte is a byte count for these codes
  function automatic logic has_count(input logic [7:0] fc, input logic kind);
    logic r;
    if (kind == 1'b0) r = (fc == 8'd15) || (fc == 8'd16) || (fc == 8'd23);
    else              r = (fc <= 8'd4) || (fc == 8'd17) || (fc == 8'd23);
    return r;
  endfunction

endpackage

/* src/mbrtu_front.sv */
// Front end: accepts input beats, classifies them and queues them.
// Depends on mbrtu_pkg and assert_macros.svh.
`include "assert_macros.svh"
module mbrtu_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  mbrtu_pkg::in_item_t in_data_i,
  output mbrtu_pkg::q_head_t  head_o,
  input  logic                pop_i
);

  mbrtu_pkg::q_item_t                      mem_q [mbrtu_pkg::QUEUE_DEPTH];
  logic [mbrtu_pkg::QPTR_W-1:0]            wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [mbrtu_pkg::QCNT_W-1:0]            cnt_q, cnt_d;
  logic                                    push;
  mbrtu_pkg::q_item_t                      cls;

  // Classify: timeouts carry no byte
  always_comb begin
    cls.is_timeout = (in_data_i.func == mbrtu_pkg::FUNC_TIMEOUT);
    cls.data       = cls.is_timeout ? 8'h00 : in_data_i.rx_byte;
  end

  assign in_stall_o = (cnt_q == mbrtu_pkg::QCNT_W'(mbrtu_pkg::QUEUE_DEPTH));
  assign push       = in_valid_i && !in_stall_o;

  assign head_o.valid = (cnt_q != '0);
  assign head_o.item  = mem_q[rd_ptr_q];

  // Pointer and count update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == mbrtu_pkg::QPTR_W'(mbrtu_pkg::QUEUE_DEPTH - 1)) ?
                 '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == mbrtu_pkg::QPTR_W'(mbrtu_pkg::QUEUE_DEPTH - 1)) ?
                 '0 : rd_ptr_q + 1'b1;
    end
    if (push && !pop_i)      cnt_d = cnt_q + 1'b1;
    else if (!push && pop_i) cnt_d = cnt_q - 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Queue storage, no reset needed
  always_ff @(posedge clk_i) begin
    if (push) mem_q[wr_ptr_q] <= cls;
  end

  `MB_ASSERT(a_no_pop_empty, pop_i |-> head_o.valid, "pop from empty queue")
  `MB_ASSERT(a_cnt_bound, cnt_q <= mbrtu_pkg::QCNT_W'(mbrtu_pkg::QUEUE_DEPTH), "queue overfilled")
  `MB_ASSERT(a_push_grows, (push && !pop_i) |=> (cnt_q == $past(cnt_q) + 1'b1), "count lost a push")

endmodule

/* src/mbrtu_back.sv */
// Back end: frame length tracking, CRC, address check and result register.
// Depends on mbrtu_pkg and assert_macros.svh.
`include "assert_macros.svh"
module mbrtu_back (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic                 cfg_idx_i,
  input  logic [7:0]           cfg_data_i,
  input  mbrtu_pkg::q_head_t   head_i,
  output logic                 pop_o,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output mbrtu_pkg::out_item_t out_data_o
);

  logic [7:0]           own_addr_q;
  logic                 kind_q;
  mbrtu_pkg::phase_e    phase_q, phase_d;
  logic [8:0]           rem_q, rem_d;
  logic [8:0]           rcv_q, rcv_d;
  logic [15:0]          crc_q, crc_d;
  logic [7:0]           func_q, func_d;
  logic [7:0]           addr_q, addr_d;
  logic                 out_valid_q, out_valid_d;
  mbrtu_pkg::out_item_t out_q, res;

  logic                           restart, meta_done;
  logic [7:0]                     count, b;
  logic [8:0]                     rcv_inc, rem_dec, need;
  logic [3:0]                     mlen;
  logic [mbrtu_pkg::LEN_W-1:0]    total;
  mbrtu_pkg::status_e             status;

  assign pop_o = head_i.valid && (!out_valid_q || !out_stall_i);
  assign b     = head_i.item.data;

  // Per-beat frame update
  always_comb begin
    phase_d   = phase_q;
    rem_d     = rem_q;
    rcv_d     = rcv_q;
    crc_d     = crc_q;
    func_d    = func_q;
    addr_d    = addr_q;
    restart   = 1'b0;
    meta_done = 1'b0;
    count     = 8'h00;
    mlen      = 4'd0;
    status    = mbrtu_pkg::ST_RECEIVING;
    rcv_inc   = rcv_q + 1'b1;
    rem_dec   = (rem_q != '0) ? rem_q - 1'b1 : rem_q;
    need      = 9'd2;
    total     = '0;
    res.byte_index    = rcv_q[7:0];
    res.data_byte     = b;
    res.function_code = 8'h00;
    res.frame_length  = 9'd0;

    if (head_i.item.is_timeout) begin
      status            = mbrtu_pkg::ST_TIMEOUT;
      res.data_byte     = 8'h00;
      res.function_code = (rcv_q >= 9'd2) ? func_q : 8'h00;
      res.frame_length  = rcv_q;
      restart           = 1'b1;
    end else begin
      crc_d   = mbrtu_pkg::crc16_byte(crc_q, b);
      addr_d  = (rcv_q == 9'd0) ? b : addr_q;
      func_d  = (rcv_q == 9'd1) ? b : func_q;
      rcv_d   = rcv_inc;
      rem_d   = rem_dec;
      res.function_code = (rcv_inc >= 9'd2) ? func_d : 8'h00;

      if (rem_dec == '0) begin
        unique case (phase_q)
          mbrtu_pkg::PH_HEAD: begin
            mlen = mbrtu_pkg::meta_length(func_d, kind_q);
            if (mlen != 4'd0) begin
              phase_d = mbrtu_pkg::PH_META;
              rem_d   = {5'd0, mlen};
            end else begin
              meta_done = 1'b1;
            end
          end
          mbrtu_pkg::PH_META: begin
            meta_done = 1'b1;
            if (mbrtu_pkg::has_count(func_d, kind_q)) count = b;
          end
          mbrtu_pkg::PH_DATA: begin
            if (addr_d != own_addr_q && addr_d != 8'h00) status = mbrtu_pkg::ST_OTHER_SLAVE;
            else if (crc_d == 16'h0000)                  status = mbrtu_pkg::ST_FRAME_OK;
            else                                         status = mbrtu_pkg::ST_CRC_ERROR;
            res.frame_length = rcv_inc;
            restart          = 1'b1;
          end
          default: begin
            restart = 1'b1;
          end
        endcase

        // End of meta part: size the data part and check the limit
        if (meta_done) begin
          need  = {1'b0, count} + 9'd2;
          total = mbrtu_pkg::LEN_W'(rcv_inc) + mbrtu_pkg::LEN_W'(need);
          if (total > mbrtu_pkg::LEN_W'(mbrtu_pkg::MAX_FRAME_BYTES)) begin
            status           = mbrtu_pkg::ST_TOO_LONG;
            res.frame_length = rcv_inc;
            restart          = 1'b1;
          end else begin
            phase_d = mbrtu_pkg::PH_DATA;
            rem_d   = need;
          end
        end
      end
    end

    res.status = status;

    if (restart) begin
      phase_d = mbrtu_pkg::PH_HEAD;
      rem_d   = 9'd2;
      rcv_d   = 9'd0;
      crc_d   = mbrtu_pkg::CRC_INIT;
      func_d  = 8'h00;
      addr_d  = 8'h00;
    end
  end

  assign out_valid_d = pop_o || (out_valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      own_addr_q  <= 8'd1;
      kind_q      <= 1'b0;
      phase_q     <= mbrtu_pkg::PH_HEAD;
      rem_q       <= 9'd2;
      rcv_q       <= 9'd0;
      crc_q       <= mbrtu_pkg::CRC_INIT;
      func_q      <= 8'h00;
      addr_q      <= 8'h00;
      out_valid_q <= 1'b0;
    end else begin
      // Configuration writes
      if (cfg_we_i && cfg_idx_i == mbrtu_pkg::CFG_OWN_ADDRESS)  own_addr_q <= cfg_data_i;
      if (cfg_we_i && cfg_idx_i == mbrtu_pkg::CFG_MESSAGE_KIND) kind_q     <= cfg_data_i[0];
      if (pop_o) begin
        phase_q <= phase_d;
        rem_q   <= rem_d;
        rcv_q   <= rcv_d;
        crc_q   <= crc_d;
        func_q  <= func_d;
        addr_q  <= addr_d;
      end
      out_valid_q <= out_valid_d;
    end
  end

  // Result register
  always_ff @(posedge clk_i) begin
    if (pop_o) out_q <= res;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  `MB_ASSERT(a_rem_nonzero, rem_q != 9'd0, "bytes remaining reached zero between beats")
  `MB_ASSERT(a_data_after_hdr, (phase_q == mbrtu_pkg::PH_DATA) |-> (rcv_q >= 9'd2), "data phase without header")
  `MB_ASSERT(a_len_bound, rcv_q <= 9'(mbrtu_pkg::MAX_FRAME_BYTES), "frame exceeded size limit")
  `MB_ASSERT(a_head_clean, (phase_q == mbrtu_pkg::PH_HEAD && rcv_q == 9'd0) |-> (crc_q == mbrtu_pkg::CRC_INIT), "crc not reset at frame start")

endmodule

/* src/modbus_rtu_frame_receiver_top.sv */
// Modbus RTU frame receiver: top level joining front queue and back end.
// Depends on mbrtu_pkg, mbrtu_front and mbrtu_back.
//
// Usage:
//   Input channel (in_valid_i / in_stall_o / in_data_i): each beat is a
//   received byte (func 0) or a timeout event (func 1).
//   Output channel (out_valid_o / out_stall_i / out_data_o): exactly one
//   result beat per input beat, in order: status, byte index, byte,
//   function code and frame length once a frame ends.
//   Config port (cfg_we_i, cfg_idx_i, cfg_data_i): index 0 own address,
//   index 1 message kind; write only while no beats are in flight.
// Path: an accepted beat passes through the two-entry queue, then the
//   result register, which drives out_data_o.
// Throughput: one beat per cycle while out_stall_i stays low; the CRC and
//   length update of one byte is combinational logic in the back end.
// Reset: the queue empties, the frame state returns to a fresh frame,
//   own address reads 1 and message kind 0.
// When the receiver stalls, the result register holds, the queue fills
//   up to two beats and then in_stall_o rises.
module modbus_rtu_frame_receiver_top (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  mbrtu_pkg::in_item_t  in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output mbrtu_pkg::out_item_t out_data_o,
  input  logic                 cfg_we_i,
  input  logic                 cfg_idx_i,
  input  logic [7:0]           cfg_data_i
);

  mbrtu_pkg::q_head_t head;
  logic               pop;

  mbrtu_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .head_o     (head),
    .pop_i      (pop)
  );

  mbrtu_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .head_i      (head),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule
